// ===== hw/rtl/assert_macros.svh =====
// assertion macros of the forward kinematics block, used by dh_forward_kinematics
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, disabled while in reset
`define DHFK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form, the consequent is checked in the cycle after the antecedent
`define DHFK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dhfk_pkg.sv =====
// types, constants and helper functions of the forward kinematics block
// used by dhfk_cordic and dh_forward_kinematics, no dependencies
package dhfk_pkg;

  localparam int ANG_W = 36;
  localparam int DAT_W = 34;
  localparam int ACC_W = 40;
  localparam int PRD_W = 2 * DAT_W;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_NEG_PI  = -36'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_NEG_HALF_PI = -36'sd1686629713;
  localparam logic signed [DAT_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0]      ONE_Q30     = 32'sd1073741824;
  localparam logic signed [PRD_W-1:0] RND_HALF    = 68'sd536870912;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_REDUCE,
    CS_FOLD,
    CS_ITER
  } cor_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_THETA,
    S_ALPHA,
    S_MAC,
    S_FLUSH,
    S_WRITE
  } fk_state_e;

  // one multiply slot: link term or pose term (row, group, term)
  typedef struct packed {
    logic       link;
    logic [2:0] lk;
    logic [1:0] row;
    logic [1:0] grp;
    logic [1:0] kk;
  } mac_tag_t;

  function automatic logic [31:0] atan_f(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(64'sd2147483647)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < ACC_W'(-64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dhfk_cordic.sv =====
// iterative cordic sine and cosine, one micro-rotation per cycle
// depends on dhfk_pkg (atan table, angle constants)
module dhfk_cordic #(
  parameter int Steps = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [16:0]              angle_i,
  output logic                            done_o,
  output logic signed [dhfk_pkg::DAT_W-1:0] sin_o,
  output logic signed [dhfk_pkg::DAT_W-1:0] cos_o
);
  import dhfk_pkg::*;

  localparam int Iters = (Steps < 31) ? Steps : 31;
  localparam logic [4:0] LastIter = 5'(Iters - 1);

  cor_state_e              state_q, state_d;
  logic signed [ANG_W-1:0] z_q, z_d, atan_s;
  logic signed [DAT_W-1:0] x_q, x_d, y_q, y_d, xsh, ysh;
  logic                    neg_q, neg_d, done_q, done_d;
  logic [4:0]              i_q, i_d;

  assign xsh    = x_q >>> i_q;
  assign ysh    = y_q >>> i_q;
  assign atan_s = signed'({4'b0000, atan_f(i_q)});

  always_comb begin
    state_d = state_q;
    z_d     = z_q;
    x_d     = x_q;
    y_d     = y_q;
    neg_d   = neg_q;
    i_d     = i_q;
    done_d  = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          z_d     = {{2{angle_i[16]}}, angle_i, 17'b0};
          x_d     = CORDIC_GAIN;
          y_d     = '0;
          neg_d   = 1'b0;
          i_d     = '0;
          state_d = CS_REDUCE;
        end
      end
      CS_REDUCE: begin
        // wrap into [-pi, pi]; a single add or subtract of two pi covers the 17-bit input range
        if (z_q > ANG_PI) begin
          z_d = z_q - ANG_TWO_PI;
        end else if (z_q < ANG_NEG_PI) begin
          z_d = z_q + ANG_TWO_PI;
        end else begin
          state_d = CS_FOLD;
        end
      end
      CS_FOLD: begin
        if (z_q > ANG_HALF_PI) begin
          z_d   = z_q - ANG_PI;
          neg_d = 1'b1;
        end else if (z_q < ANG_NEG_HALF_PI) begin
          z_d   = z_q + ANG_PI;
          neg_d = 1'b1;
        end
        state_d = CS_ITER;
      end
      CS_ITER: begin
        if (!z_q[ANG_W-1]) begin
          x_d = x_q - ysh;
          y_d = y_q + xsh;
          z_d = z_q - atan_s;
        end else begin
          x_d = x_q + ysh;
          y_d = y_q - xsh;
          z_d = z_q + atan_s;
        end
        i_d = i_q + 5'd1;
        if (i_q == LastIter) begin
          state_d = CS_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    x_q   <= x_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    i_q   <= i_d;
  end

  assign done_o = done_q;
  assign sin_o  = neg_q ? -y_q : y_q;
  assign cos_o  = neg_q ? -x_q : x_q;

endmodule

// ===== hw/rtl/dh_forward_kinematics.sv =====
// forward kinematics of a serial chain of dh links, one joint per input transfer
// depends on dhfk_pkg, dhfk_cordic and assert_macros.svh
//
//  channel | handshake             | payload
//  in      | in_valid_i/in_ready_o | joint angle, d, a, alpha, theta offset, last flag
//  out     | out_valid_o/out_ready_i | rot_00..rot_22, pos_x/y/z
//
// a joint is made of:
// two cordic runs, one for theta and one for alpha (each with its angle wrap passes),
// 42 multiplies on the shared multiplier, and the accept, flush and write cycles
// the pose is identity after reset and again after each last joint
// in_ready_o is high only while idle; a full output register stalls a last joint
`include "assert_macros.svh"

module dh_forward_kinematics #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] joint_angle_i,
  input  logic signed [31:0] link_offset_d_i,
  input  logic signed [31:0] link_length_a_i,
  input  logic signed [15:0] link_twist_alpha_i,
  input  logic signed [15:0] angle_offset_i,
  input  logic               last_joint_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rot_00_o,
  output logic signed [31:0] rot_01_o,
  output logic signed [31:0] rot_02_o,
  output logic signed [31:0] rot_10_o,
  output logic signed [31:0] rot_11_o,
  output logic signed [31:0] rot_12_o,
  output logic signed [31:0] rot_20_o,
  output logic signed [31:0] rot_21_o,
  output logic signed [31:0] rot_22_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o
);
  import dhfk_pkg::*;

  fk_state_e state_q, state_d;

  logic signed [31:0] d_q, d_d, a_q, a_d;
  logic signed [15:0] alpha_q, alpha_d;
  logic               last_q, last_d;

  logic signed [DAT_W-1:0] st_q, st_d, ct_q, ct_d, sa_q, sa_d, ca_q, ca_d;
  logic signed [31:0] lr1_q, lr1_d, lr2_q, lr2_d, lr4_q, lr4_d, lr5_q, lr5_d;
  logic signed [31:0] lt0_q, lt0_d, lt1_q, lt1_d;

  logic signed [31:0] pose_rot_q [9];
  logic signed [31:0] pose_rot_d [9];
  logic signed [31:0] pose_pos_q [3];
  logic signed [31:0] pose_pos_d [3];
  logic signed [31:0] new_rot_q  [9];
  logic signed [31:0] new_rot_d  [9];
  logic signed [31:0] new_pos_q  [3];
  logic signed [31:0] new_pos_d  [3];
  logic signed [31:0] out_rot_q  [9];
  logic signed [31:0] out_rot_d  [9];
  logic signed [31:0] out_pos_q  [3];
  logic signed [31:0] out_pos_d  [3];
  logic               out_valid_q, out_valid_d;

  mac_tag_t tag_q, tag_d, ptag_q, ptag_d;
  logic     pv_q, pv_d;

  logic signed [DAT_W-1:0] op_a, op_b;
  logic signed [PRD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, rp, sum;
  logic [3:0]              idx_a, idx_w;

  logic                    cor_start, cor_done;
  logic signed [16:0]      cor_angle;
  logic signed [DAT_W-1:0] cor_sin, cor_cos;

  dhfk_cordic #(
    .Steps(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cor_start),
    .angle_i(cor_angle),
    .done_o (cor_done),
    .sin_o  (cor_sin),
    .cos_o  (cor_cos)
  );

  // operand select for the issue slot
  assign idx_a = 4'(tag_q.row) * 4'd3 + 4'(tag_q.kk);

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (tag_q.link) begin
      case (tag_q.lk)
        3'd0: begin op_a = st_q; op_b = ca_q; end
        3'd1: begin op_a = st_q; op_b = sa_q; end
        3'd2: begin op_a = ct_q; op_b = ca_q; end
        3'd3: begin op_a = ct_q; op_b = sa_q; end
        3'd4: begin op_a = DAT_W'(a_q); op_b = ct_q; end
        3'd5: begin op_a = DAT_W'(a_q); op_b = st_q; end
        default: ;
      endcase
    end else begin
      op_a = DAT_W'(pose_rot_q[idx_a]);
      case ({tag_q.grp, tag_q.kk})
        {2'd0, 2'd0}: op_b = DAT_W'(lt0_q);
        {2'd0, 2'd1}: op_b = DAT_W'(lt1_q);
        {2'd0, 2'd2}: op_b = DAT_W'(d_q);
        {2'd1, 2'd0}: op_b = ct_q;
        {2'd1, 2'd1}: op_b = st_q;
        {2'd2, 2'd0}: op_b = DAT_W'(lr1_q);
        {2'd2, 2'd1}: op_b = DAT_W'(lr4_q);
        {2'd2, 2'd2}: op_b = sa_q;
        {2'd3, 2'd0}: op_b = DAT_W'(lr2_q);
        {2'd3, 2'd1}: op_b = DAT_W'(lr5_q);
        {2'd3, 2'd2}: op_b = ca_q;
        default: op_b = '0;
      endcase
    end
  end

  assign prod_d = op_a * op_b;
  // round half up, then back to q1.30
  assign rp     = ACC_W'((prod_q + RND_HALF) >>> 30);
  assign idx_w  = 4'(ptag_q.row) * 4'd3 + 4'(ptag_q.grp) - 4'd1;

  // accumulate stage
  always_comb begin
    lr1_d     = lr1_q;
    lr2_d     = lr2_q;
    lr4_d     = lr4_q;
    lr5_d     = lr5_q;
    lt0_d     = lt0_q;
    lt1_d     = lt1_q;
    acc_d     = acc_q;
    new_rot_d = new_rot_q;
    new_pos_d = new_pos_q;
    sum       = '0;
    if (pv_q) begin
      if (ptag_q.link) begin
        case (ptag_q.lk)
          3'd0: lr1_d = 32'(-rp);
          3'd1: lr2_d = rp[31:0];
          3'd2: lr4_d = rp[31:0];
          3'd3: lr5_d = 32'(-rp);
          3'd4: lt0_d = sat32(rp);
          3'd5: lt1_d = sat32(rp);
          default: ;
        endcase
      end else begin
        if (ptag_q.kk == 2'd0) begin
          sum = ((ptag_q.grp == 2'd0) ? ACC_W'(pose_pos_q[ptag_q.row]) : '0) + rp;
        end else begin
          sum = acc_q + rp;
        end
        acc_d = sum;
        if (ptag_q.kk == 2'd2) begin
          if (ptag_q.grp == 2'd0) begin
            new_pos_d[ptag_q.row] = sat32(sum);
          end else begin
            new_rot_d[idx_w] = sat32(sum);
          end
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cor_start   = 1'b0;
    cor_angle   = {joint_angle_i[15], joint_angle_i} + {angle_offset_i[15], angle_offset_i};
    d_d         = d_q;
    a_d         = a_q;
    alpha_d     = alpha_q;
    last_d      = last_q;
    st_d        = st_q;
    ct_d        = ct_q;
    sa_d        = sa_q;
    ca_d        = ca_q;
    tag_d       = tag_q;
    ptag_d      = tag_q;
    pv_d        = 1'b0;
    pose_rot_d  = pose_rot_q;
    pose_pos_d  = pose_pos_q;
    out_rot_d   = out_rot_q;
    out_pos_d   = out_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          d_d       = link_offset_d_i;
          a_d       = link_length_a_i;
          alpha_d   = link_twist_alpha_i;
          last_d    = last_joint_i;
          cor_start = 1'b1;
          state_d   = S_THETA;
        end
      end
      S_THETA: begin
        cor_angle = {alpha_q[15], alpha_q};
        if (cor_done) begin
          st_d      = cor_sin;
          ct_d      = cor_cos;
          cor_start = 1'b1;
          state_d   = S_ALPHA;
        end
      end
      S_ALPHA: begin
        if (cor_done) begin
          sa_d       = cor_sin;
          ca_d       = cor_cos;
          tag_d      = '0;
          tag_d.link = 1'b1;
          state_d    = S_MAC;
        end
      end
      S_MAC: begin
        pv_d = 1'b1;
        if (tag_q.link) begin
          if (tag_q.lk == 3'd5) begin
            tag_d = '0;
          end else begin
            tag_d.lk = tag_q.lk + 3'd1;
          end
        end else if (tag_q.kk == 2'd2) begin
          tag_d.kk = 2'd0;
          if (tag_q.grp == 2'd3) begin
            tag_d.grp = 2'd0;
            if (tag_q.row == 2'd2) begin
              state_d = S_FLUSH;
            end else begin
              tag_d.row = tag_q.row + 2'd1;
            end
          end else begin
            tag_d.grp = tag_q.grp + 2'd1;
          end
        end else begin
          tag_d.kk = tag_q.kk + 2'd1;
        end
      end
      S_FLUSH: state_d = S_WRITE;
      S_WRITE: begin
        if (!(last_q && out_valid_q && !out_ready_i)) begin
          if (last_q) begin
            out_rot_d   = new_rot_q;
            out_pos_d   = new_pos_q;
            out_valid_d = 1'b1;
            for (int k = 0; k < 9; k++) begin
              pose_rot_d[k] = (k % 4 == 0) ? ONE_Q30 : '0;
            end
            for (int k = 0; k < 3; k++) begin
              pose_pos_d[k] = '0;
            end
          end else begin
            pose_rot_d = new_rot_q;
            pose_pos_d = new_pos_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        pose_rot_q[k] <= (k % 4 == 0) ? ONE_Q30 : '0;
      end
      for (int k = 0; k < 3; k++) begin
        pose_pos_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
      pose_rot_q  <= pose_rot_d;
      pose_pos_q  <= pose_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q       <= d_d;
    a_q       <= a_d;
    alpha_q   <= alpha_d;
    last_q    <= last_d;
    st_q      <= st_d;
    ct_q      <= ct_d;
    sa_q      <= sa_d;
    ca_q      <= ca_d;
    lr1_q     <= lr1_d;
    lr2_q     <= lr2_d;
    lr4_q     <= lr4_d;
    lr5_q     <= lr5_d;
    lt0_q     <= lt0_d;
    lt1_q     <= lt1_d;
    tag_q     <= tag_d;
    ptag_q    <= ptag_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    new_rot_q <= new_rot_d;
    new_pos_q <= new_pos_d;
    out_rot_q <= out_rot_d;
    out_pos_q <= out_pos_d;
  end

  assign out_valid_o = out_valid_q;
  assign rot_00_o    = out_rot_q[0];
  assign rot_01_o    = out_rot_q[1];
  assign rot_02_o    = out_rot_q[2];
  assign rot_10_o    = out_rot_q[3];
  assign rot_11_o    = out_rot_q[4];
  assign rot_12_o    = out_rot_q[5];
  assign rot_20_o    = out_rot_q[6];
  assign rot_21_o    = out_rot_q[7];
  assign rot_22_o    = out_rot_q[8];
  assign pos_x_o     = out_pos_q[0];
  assign pos_y_o     = out_pos_q[1];
  assign pos_z_o     = out_pos_q[2];

  `DHFK_ASSERT(a_out_from_write, $rose(out_valid_q) |-> $past(state_q == S_WRITE), "result raised outside write")
  `DHFK_ASSERT(a_idle_no_mac, (state_q == S_IDLE) |-> !pv_q, "multiply slot live while idle")
  `DHFK_ASSERT(a_cor_phase, cor_done |-> (state_q == S_THETA || state_q == S_ALPHA), "cordic done out of phase")
  `DHFK_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_THETA, "accepted joint did not start")

endmodule

// ===== tb/dh_pose_checker.sv =====
// pose checker for dh_forward_kinematics: watches both channels, predicts each chain-end pose
// depends on nothing but the block's port widths
module dh_pose_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] joint_angle_i,
  input  logic signed [31:0] link_offset_d_i,
  input  logic signed [31:0] link_length_a_i,
  input  logic signed [15:0] link_twist_alpha_i,
  input  logic signed [15:0] angle_offset_i,
  input  logic               last_joint_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [11:0][31:0]  pose_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint ATAN_TAB [31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001};

  typedef logic [11:0][31:0] pose_vec_t;

  longint    pose_rot [9];
  longint    pose_pos [3];
  pose_vec_t chain_end_poses [$];

  assign pending_o = chain_end_poses.size();

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic sin_cos(input longint ang_q13, output longint s, output longint c);
    longint z, x, y, nx;
    bit     flip;
    z = ang_q13 * 131072;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    if (z < -PI_Q30) z += TWO_PI_Q30;
    if (z < -PI_Q30) z += TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 31; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic clear_pose();
    for (int k = 0; k < 9; k++) pose_rot[k] = (k % 4 == 0) ? ONE_Q30 : 0;
    for (int k = 0; k < 3; k++) pose_pos[k] = 0;
  endtask

  task automatic chain_joint();
    longint    st, ct, sa, ca, acc;
    longint    lr [9];
    longint    lt [3];
    longint    nr [9];
    longint    nt [3];
    pose_vec_t res;
    sin_cos(longint'(joint_angle_i) + longint'(angle_offset_i), st, ct);
    sin_cos(longint'(link_twist_alpha_i), sa, ca);
    lr = '{ct, -mul_q30(st, ca), mul_q30(st, sa),
           st, mul_q30(ct, ca), -mul_q30(ct, sa),
           0, sa, ca};
    lt[0] = clamp32(mul_q30(longint'(link_length_a_i), ct));
    lt[1] = clamp32(mul_q30(longint'(link_length_a_i), st));
    lt[2] = longint'(link_offset_d_i);
    for (int r = 0; r < 3; r++) begin
      acc = pose_pos[r];
      for (int c = 0; c < 3; c++) acc += mul_q30(pose_rot[r*3+c], lt[c]);
      nt[r] = clamp32(acc);
      for (int c = 0; c < 3; c++) begin
        nr[r*3+c] = clamp32(mul_q30(pose_rot[r*3], lr[c]) + mul_q30(pose_rot[r*3+1], lr[3+c])
                            + mul_q30(pose_rot[r*3+2], lr[6+c]));
      end
    end
    pose_rot = nr;
    pose_pos = nt;
    if (last_joint_i) begin
      for (int k = 0; k < 9; k++) res[k] = pose_rot[k][31:0];
      for (int k = 0; k < 3; k++) res[9+k] = pose_pos[k][31:0];
      chain_end_poses = {chain_end_poses, res};
      clear_pose();
    end
  endtask

  initial begin
    fail_count_o = 0;
    clear_pose();
  end

  always @(posedge clk_i) begin
    pose_vec_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) chain_joint();
      if (out_valid_i && out_ready_i) begin
        if (chain_end_poses.size() == 0) begin
          $display("%0t: pose transfer with nothing expected", $time);
          fail_count_o++;
        end else begin
          want = chain_end_poses.pop_front();
          for (int k = 0; k < 12; k++) begin
            if (want[k] !== pose_i[k]) begin
              // fields 0..8 are rotation row-major, 9..11 translation x/y/z
              $display("%0t: pose field %0d expected %0d actual %0d", $time, k,
                       $signed(want[k]), $signed(pose_i[k]));
              fail_count_o++;
            end
          end
        end
      end
    end
  end

endmodule

// ===== tb/dh_forward_kinematics_tb.sv =====
// testbench top for dh_forward_kinematics: drives joints, stalls the output, gives the verdict
// depends on dh_pose_checker and the block itself
module dh_forward_kinematics_tb;

  localparam int  NUM_RANDOM  = 380;
  localparam int  QUIET_TAIL  = 40;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  LONG_HOLD   = 1500;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] joint_angle = '0;
  logic signed [31:0] offset_d = '0;
  logic signed [31:0] length_a = '0;
  logic signed [15:0] twist_alpha = '0;
  logic signed [15:0] angle_off = '0;
  logic               last_joint = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [11:0][31:0]  pose;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  bit                 quiet = 0;
  bit                 hold_done = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dh_forward_kinematics DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .joint_angle_i(joint_angle), .link_offset_d_i(offset_d), .link_length_a_i(length_a),
    .link_twist_alpha_i(twist_alpha), .angle_offset_i(angle_off), .last_joint_i(last_joint),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .rot_00_o(pose[0]), .rot_01_o(pose[1]), .rot_02_o(pose[2]),
    .rot_10_o(pose[3]), .rot_11_o(pose[4]), .rot_12_o(pose[5]),
    .rot_20_o(pose[6]), .rot_21_o(pose[7]), .rot_22_o(pose[8]),
    .pos_x_o(pose[9]), .pos_y_o(pose[10]), .pos_z_o(pose[11])
  );

  dh_pose_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .joint_angle_i(joint_angle), .link_offset_d_i(offset_d), .link_length_a_i(length_a),
    .link_twist_alpha_i(twist_alpha), .angle_offset_i(angle_off), .last_joint_i(last_joint),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .pose_i(pose),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: one long hold-off first so the block backs up, then random stall bursts
  initial begin
    repeat (11) @(posedge clk_i);
    repeat (LONG_HOLD) @(posedge clk_i);
    hold_done = 1;
    forever begin
      out_ready <= 1'b1;
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'($signed($urandom_range(0, 25736)) - 12868);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 6))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 262144)) - 131072);
      default: return 32'($urandom);
    endcase
  endfunction

  // offers one joint and returns once it has been taken
  task automatic send_joint(input logic [15:0] ang, input logic [31:0] d, input logic [31:0] a,
                            input logic [15:0] alp, input logic [15:0] off, input logic lst);
    joint_angle <= ang;
    offset_d    <= d;
    length_a    <= a;
    twist_alpha <= alp;
    angle_off   <= off;
    last_joint  <= lst;
    in_valid    <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  initial begin
    int sent;
    int chain_len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, wrap of the summed angle, single-joint and short chains
    send_joint(16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_joint(16'sh8000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000, 1'b1);
    send_joint('0, '0, '0, '0, '0, 1'b1);
    send_joint(16'sh7FFF, 32'sd65536, 32'sd65536, '0, 16'sh8000, 1'b1);
    send_joint(16'sd12868, 32'sd0, 32'sd131072, 16'sd12868, '0, 1'b1);
    send_joint(16'sd25736, 32'sd0, 32'sd131072, -16'sd12868, '0, 1'b1);
    send_joint(16'sd12867, 32'sd1000, -32'sd1000, 16'sd12869, 16'sd1, 1'b0);
    send_joint(-16'sd12867, -32'sd1000, 32'sd1000, -16'sd12869, -16'sd1, 1'b1);
    // saturation of the growing translation
    for (int k = 0; k < 6; k++) begin
      send_joint('0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, '0, '0, k == 5);
    end
    for (int k = 0; k < 6; k++) begin
      send_joint(16'sh8000, 32'sh80000000, 32'sh7FFFFFFF, 16'sh7FFF, '0, k == 5);
    end
    sent = 20;

    // random chains, with occasional fully random noise joints in between
    while (sent < 20 + NUM_RANDOM) begin
      if (20 + NUM_RANDOM - sent < QUIET_TAIL && hold_done) quiet = 1;
      if ($urandom_range(0, 9) == 0) begin
        send_joint(16'($urandom), 32'($urandom), 32'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom));
        sent++;
      end else begin
        chain_len = $urandom_range(1, 8);
        for (int k = 0; k < chain_len; k++) begin
          send_joint(pick_angle(), pick_length(), pick_length(), pick_angle(), pick_angle(),
                     k == chain_len - 1);
          sent++;
        end
      end
    end
    quiet = 1;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dhfk_pkg.sv
hw/rtl/dhfk_cordic.sv
hw/rtl/dh_forward_kinematics.sv
tb/dh_pose_checker.sv
tb/dh_forward_kinematics_tb.sv
